/* design/spring_damper_smoother_unit_assert.svh */
// Assertion macros used by the checker file sds_checker.sv.
// Needs signals clk and arst_n in the scope of use.
`ifndef SPRING_DAMPER_SMOOTHER_UNIT_ASSERT_SVH
`define SPRING_DAMPER_SMOOTHER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sds_pkg.sv */
// Types and constants for the spring-damper smoother.
// No dependencies.
package sds_pkg;

	localparam int POS_W  = 20;
	localparam int VEL_W  = 32;
	localparam int TIME_W = 32;
	localparam int DT_W   = 20;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_STIFFNESS     = 3'd0;
	localparam logic [IDX_W-1:0] REG_DAMPING       = 3'd1;
	localparam logic [IDX_W-1:0] REG_POS_TOLERANCE = 3'd2;
	localparam logic [IDX_W-1:0] REG_VEL_TOLERANCE = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_STEP      = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEFAULT_STEP  = 3'd5;

	localparam logic [9:0]      RST_STIFFNESS     = 10'd120;
	localparam logic [7:0]      RST_DAMPING       = 8'd14;
	localparam logic [15:0]     RST_POS_TOLERANCE = 16'd33;
	localparam logic [15:0]     RST_VEL_TOLERANCE = 16'd66;
	localparam logic [DT_W-1:0] RST_MAX_STEP      = 20'd104858;
	localparam logic [DT_W-1:0] RST_DEFAULT_STEP  = 20'd17476;

	// round to nearest, ties away from zero, on a shift by 20
	localparam int TICK_SHIFT = 20;
	localparam logic signed [63:0] RND_POS = 64'sd524288;
	localparam logic signed [63:0] RND_NEG = 64'sd524287;

	typedef struct packed {
		logic signed [POS_W-1:0] target;
		logic [TIME_W-1:0]       now_ticks;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    moving;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic snap;
		logic step_dt;
		logic mac_kx;
		logic mac_cv;
		logic mul_al;
		logic mac_ah;
		logic rnd;
		logic vsat;
		logic mul_vp;
		logic psat;
		logic commit;
	} ctrl_t;

endpackage

/* design/sds_seq.sv */
// Sequencer for the spring-damper smoother: steps the shared multiplier.
// Depends on sds_pkg.
module sds_seq import sds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output ctrl_t ctrl
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_FIRST = 13'b0000000000010,
		S_DT    = 13'b0000000000100,
		S_KX    = 13'b0000000001000,
		S_CV    = 13'b0000000010000,
		S_AL    = 13'b0000000100000,
		S_AH    = 13'b0000001000000,
		S_RV    = 13'b0000010000000,
		S_VS    = 13'b0000100000000,
		S_VP    = 13'b0001000000000,
		S_RP    = 13'b0010000000000,
		S_PS    = 13'b0100000000000,
		S_CK    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   started_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.capture = 1'b1;
					state_d = started_q ? S_DT : S_FIRST;
				end
			end
			S_FIRST: begin
				if (slot_free) begin
					ctrl.snap = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DT: begin
				ctrl.step_dt = 1'b1;
				state_d = S_KX;
			end
			S_KX: begin
				ctrl.mac_kx = 1'b1;
				state_d = S_CV;
			end
			S_CV: begin
				ctrl.mac_cv = 1'b1;
				state_d = S_AL;
			end
			S_AL: begin
				ctrl.mul_al = 1'b1;
				state_d = S_AH;
			end
			S_AH: begin
				ctrl.mac_ah = 1'b1;
				state_d = S_RV;
			end
			S_RV: begin
				ctrl.rnd = 1'b1;
				state_d = S_VS;
			end
			S_VS: begin
				ctrl.vsat = 1'b1;
				state_d = S_VP;
			end
			S_VP: begin
				ctrl.mul_vp = 1'b1;
				state_d = S_RP;
			end
			S_RP: begin
				ctrl.rnd = 1'b1;
				state_d = S_PS;
			end
			S_PS: begin
				ctrl.psat = 1'b1;
				state_d = S_CK;
			end
			S_CK: begin
				if (slot_free) begin
					ctrl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.snap) begin
				started_q <= 1'b1;
			end
			if (ctrl.snap || ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/sds_dpath.sv */
// Datapath for the spring-damper smoother: config registers, state and
// one shared signed multiplier with accumulator. Depends on sds_pkg.
module sds_dpath import sds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  ctrl_t            ctrl,
	input  in_word_t         in_data,
	output out_word_t        out_data
);

	logic [9:0]      stiff_q;
	logic [7:0]      damp_q;
	logic [15:0]     ptol_q;
	logic [15:0]     vtol_q;
	logic [DT_W-1:0] maxs_q;
	logic [DT_W-1:0] defs_q;

	logic signed [POS_W-1:0] tgt_q;
	logic [TIME_W-1:0]       now_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [TIME_W-1:0]       last_q;

	logic [DT_W-1:0]         dt_q;
	logic signed [POS_W:0]   dx_q;
	logic signed [41:0]      acc_q;
	logic signed [63:0]      prod_q;
	logic signed [VEL_W-1:0] vnew_q;
	logic signed [POS_W-1:0] pnew_q;
	logic                    vconv_q;
	logic signed [POS_W-1:0] opos_q;
	logic                    omov_q;

	logic signed [32:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [54:0] mul_p;
	logic signed [63:0] mul_x;

	logic [TIME_W-1:0]  diff;
	logic signed [63:0] rnd_add;
	logic signed [63:0] rsum;
	logic signed [43:0] vsum;
	logic signed [33:0] psum;
	logic [VEL_W:0]     vabs;
	logic signed [POS_W:0] perr;
	logic [POS_W:0]     pabs;
	logic               pconv;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (ctrl.mac_kx) begin
			mul_a = {{12{dx_q[POS_W]}}, dx_q};
			mul_b = {12'd0, stiff_q};
		end else if (ctrl.mac_cv) begin
			mul_a = {vel_q[VEL_W-1], vel_q};
			mul_b = {14'd0, damp_q};
		end else if (ctrl.mul_al) begin
			mul_a = {12'd0, acc_q[20:0]};
			mul_b = {2'd0, dt_q};
		end else if (ctrl.mac_ah) begin
			mul_a = {{12{acc_q[41]}}, acc_q[41:21]};
			mul_b = {2'd0, dt_q};
		end else if (ctrl.mul_vp) begin
			mul_a = {vnew_q[VEL_W-1], vnew_q};
			mul_b = {2'd0, dt_q};
		end
	end

	assign mul_p   = mul_a * mul_b;
	assign mul_x   = {{9{mul_p[54]}}, mul_p};
	assign diff    = now_q - last_q;
	assign rnd_add = prod_q[63] ? RND_NEG : RND_POS;
	assign rsum    = prod_q + rnd_add;
	assign vsum    = {{12{vel_q[VEL_W-1]}}, vel_q} + prod_q[43:0];
	assign psum    = {{14{pos_q[POS_W-1]}}, pos_q} + prod_q[33:0];
	assign vabs    = vnew_q[VEL_W-1] ? (33'd0 - {vnew_q[VEL_W-1], vnew_q})
		: {1'b0, vnew_q};
	assign perr    = {pnew_q[POS_W-1], pnew_q} - {tgt_q[POS_W-1], tgt_q};
	assign pabs    = perr[POS_W] ? (21'd0 - perr) : perr;
	assign pconv   = pabs < {5'd0, ptol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= RST_STIFFNESS;
			damp_q  <= RST_DAMPING;
			ptol_q  <= RST_POS_TOLERANCE;
			vtol_q  <= RST_VEL_TOLERANCE;
			maxs_q  <= RST_MAX_STEP;
			defs_q  <= RST_DEFAULT_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFFNESS:     stiff_q <= cfg_data[9:0];
				REG_DAMPING:       damp_q  <= cfg_data[7:0];
				REG_POS_TOLERANCE: ptol_q  <= cfg_data[15:0];
				REG_VEL_TOLERANCE: vtol_q  <= cfg_data[15:0];
				REG_MAX_STEP:      maxs_q  <= cfg_data;
				REG_DEFAULT_STEP:  defs_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			vel_q  <= '0;
			last_q <= '0;
		end else begin
			if (ctrl.snap) begin
				pos_q  <= tgt_q;
				vel_q  <= '0;
				last_q <= now_q;
			end
			if (ctrl.step_dt) begin
				last_q <= now_q;
			end
			if (ctrl.commit) begin
				if (pconv && vconv_q) begin
					pos_q <= tgt_q;
					vel_q <= '0;
				end else begin
					pos_q <= pnew_q;
					vel_q <= vnew_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			tgt_q <= in_data.target;
			now_q <= in_data.now_ticks;
		end
		if (ctrl.step_dt) begin
			if (diff == '0 || diff[TIME_W-1]) begin
				dt_q <= defs_q;
			end else if (diff > {12'd0, maxs_q}) begin
				dt_q <= maxs_q;
			end else begin
				dt_q <= diff[DT_W-1:0];
			end
			dx_q <= {pos_q[POS_W-1], pos_q} - {tgt_q[POS_W-1], tgt_q};
		end
		if (ctrl.mac_kx) begin
			acc_q <= -$signed(mul_p[41:0]);
		end
		if (ctrl.mac_cv) begin
			acc_q <= acc_q - $signed(mul_p[41:0]);
		end
		if (ctrl.mul_al || ctrl.mul_vp) begin
			prod_q <= mul_x;
		end
		if (ctrl.mac_ah) begin
			prod_q <= prod_q + (mul_x <<< 21);
		end
		if (ctrl.rnd) begin
			prod_q <= rsum >>> TICK_SHIFT;
		end
		if (ctrl.vsat) begin
			if (!vsum[43] && (|vsum[42:31])) begin
				vnew_q <= {1'b0, {(VEL_W-1){1'b1}}};
			end else if (vsum[43] && !(&vsum[42:31])) begin
				vnew_q <= {1'b1, {(VEL_W-1){1'b0}}};
			end else begin
				vnew_q <= vsum[VEL_W-1:0];
			end
		end
		if (ctrl.mul_vp) begin
			vconv_q <= vabs < {17'd0, vtol_q};
		end
		if (ctrl.psat) begin
			if (!psum[33] && (|psum[32:19])) begin
				pnew_q <= {1'b0, {(POS_W-1){1'b1}}};
			end else if (psum[33] && !(&psum[32:19])) begin
				pnew_q <= {1'b1, {(POS_W-1){1'b0}}};
			end else begin
				pnew_q <= psum[POS_W-1:0];
			end
		end
		if (ctrl.snap) begin
			opos_q <= tgt_q;
			omov_q <= 1'b0;
		end
		if (ctrl.commit) begin
			if (pconv && vconv_q) begin
				opos_q <= tgt_q;
				omov_q <= 1'b0;
			end else begin
				opos_q <= pnew_q;
				omov_q <= 1'b1;
			end
		end
	end

	assign out_data.position = opos_q;
	assign out_data.moving   = omov_q;

endmodule

/* design/spring_damper_smoother_unit.sv */
// Spring-damper smoother: one word in, one word out; the first word after reset
// only snaps position to its target. in_ready is low while a word is worked.
// Each word steps the shared 33x22 multiplier through five products and
// two rounding passes through its accumulator. Result sits in an output
// register; a new word is taken while it waits. Async active-low reset
// restores register defaults and clears position, velocity and started.
module spring_damper_smoother_unit import sds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data
);

	ctrl_t ctrl;

	sds_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	sds_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.in_data   (in_data),
		.out_data  (out_data)
	);

endmodule

/* design/sds_checker.sv */
// Port-level checks for the spring-damper smoother, bound to the top level.
// Depends on sds_pkg and spring_damper_smoother_unit_assert.svh.
`include "spring_damper_smoother_unit_assert.svh"
module sds_checker import sds_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	logic unused_in;
	assign unused_in = in_valid ^ (^in_data);

	`SDS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`SDS_ASSERT_SAME(a_idle_on_result, $rose(out_valid), in_ready, "result while busy")
	`SDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output dropped")

endmodule

bind spring_damper_smoother_unit sds_checker u_sds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
